>>> sv/tlbib_pkg.sv
// ----------------------------------------------------------------------------
// tlbib_pkg
// Shared types and constants for the TLB invalidate batcher.
// ----------------------------------------------------------------------------
package tlbib_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 2);

   // address / command layout
   localparam int ADDR_W     = 64;
   localparam int VALUE_W    = 64;
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_W     = 44;
   localparam int ASID_W     = 8;
   localparam int ASID_POS   = 48;
   localparam int KIND_W     = 2;

   // config port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = ASID_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CONTEXT_ASID   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_CONTEXT = CSR_IDX_W'(1);

   // request operations
   localparam logic OP_QUEUE = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_VA_ALL  = 2'd0,
      KIND_VA_ASID = 2'd1,
      KIND_ASID    = 2'd2,
      KIND_BARRIER = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_WHOLE,
      ST_BARRIER
   } state_type;

endpackage

>>> sv/tlbib_if.sv
// ----------------------------------------------------------------------------
// tlbib_if
// Valid/ready channels for the TLB invalidate batcher requests and commands.
// ----------------------------------------------------------------------------
interface tlbib_req_if
   import tlbib_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [ADDR_W-1:0] virt_addr;

   modport source (output valid, output operation, output virt_addr, input ready);
   modport sink   (input valid, input operation, input virt_addr, output ready);
endinterface

interface tlbib_rsp_if
   import tlbib_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  command_kind;
   logic [VALUE_W-1:0] command_value;
   logic               last;

   modport source (output valid, output command_kind, output command_value,
                   output last, input ready);
   modport sink   (input valid, input command_kind, input command_value,
                   input last, output ready);
endinterface

>>> sv/tlb_invalidate_batcher.sv
// ----------------------------------------------------------------------------
// tlb_invalidate_batcher
// Collects page invalidations for one address space and drains them as
// a stream of TLB invalidate commands closed by a barrier.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan : request transactions. operation = queue (store page of
//              virt_addr) or flush (drain the queue).
//   rsp_chan : command transactions (kind, value, last). last marks the
//              barrier, the final command of a flush.
//   csr_*    : write-only registers, context ASID and kernel flag; write
//              them only while no request is in flight.
// Flow:
//   A queue transaction stores the page or only bumps the count;
//   back-to-back queues run at one per cycle while no flush is draining.
//   A flush (or a kernel queue that hits a full queue) holds req ready low
//   while it drains; entries leave the page RAM one per cycle while rsp
//   ready is high (registered read, prefetched). Each entry moves from
//   the read register to the output register; the barrier follows the last
//   entry. An empty queue goes to the barrier; an overflowed one sends
//   whole-ASID first. req ready rises again once the barrier is shown.
// Reset: count cleared, config and state registers zero, output empty.
//   The page RAM has no reset; only entries below the count are ever read.
// Stall: a single output register holds the pending command; while it is
//   full and rsp ready is low, the drain and a full prefetch register pause.
// ----------------------------------------------------------------------------
module tlb_invalidate_batcher
   import tlbib_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tlbib_req_if.sink             req_chan,
   tlbib_rsp_if.source           rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] OVF_CNT   = CNT_W'(QUEUE_DEPTH + 1);

   // config registers
   logic [ASID_W-1:0] asid_ff;
   logic              kernel_ff;

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;     // next entry to fetch
   logic              q_valid_ff, q_valid_in;   // RAM read data holds an entry
   logic              store_after_ff, store_after_in;
   logic [PAGE_W-1:0] held_page_ff, held_page_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   // page RAM
   logic [PAGE_W-1:0] page_mem [QUEUE_DEPTH];
   logic [PAGE_W-1:0] mem_rdata_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [PAGE_W-1:0] mem_wdata;
   logic              rd_en;

   logic              req_fire;
   logic              out_load;
   logic              overflow;
   logic [PAGE_W-1:0] req_page;
   logic [VALUE_W-1:0] asid_bits;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_page       = req_chan.virt_addr[PAGE_SHIFT +: PAGE_W];
   assign overflow       = (count_ff > DEPTH_CNT);
   assign out_load       = !rsp_valid_ff || rsp_chan.ready;
   assign asid_bits      = {{(VALUE_W - ASID_POS - ASID_W){1'b0}}, asid_ff,
                            {ASID_POS{1'b0}}};

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.command_kind  = rsp_kind_ff;
   assign rsp_chan.command_value = rsp_value_ff;
   assign rsp_chan.last          = rsp_last_ff;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         asid_ff   <= '0;
         kernel_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CONTEXT_ASID:   asid_ff   <= csr_write_data[ASID_W-1:0];
            CSR_KERNEL_CONTEXT: kernel_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // next state and outputs
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rd_idx_in      = rd_idx_ff;
      q_valid_in     = q_valid_ff;
      store_after_in = store_after_ff;
      held_page_in   = held_page_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      mem_waddr      = count_ff[IDX_W-1:0];
      mem_wdata      = req_page;
      rd_en          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.operation == OP_FLUSH) begin
                  rd_idx_in      = '0;
                  store_after_in = 1'b0;
                  state_in       = overflow ? ST_WHOLE : ST_DRAIN;
               end else if (count_ff < DEPTH_CNT) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else if (!kernel_ff) begin
                  count_in = OVF_CNT;   // user: saturate, whole-ASID later
               end else begin
                  // kernel: flush first, then store the page in slot 0
                  held_page_in   = req_page;
                  store_after_in = 1'b1;
                  rd_idx_in      = '0;
                  state_in       = overflow ? ST_WHOLE : ST_DRAIN;
               end
            end
         end

         ST_DRAIN: begin
            if (q_valid_ff && out_load) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               if (kernel_ff) begin
                  rsp_kind_in  = KIND_VA_ALL;
                  rsp_value_in = {{(VALUE_W - PAGE_W){1'b0}}, mem_rdata_ff};
               end else begin
                  rsp_kind_in  = KIND_VA_ASID;
                  rsp_value_in = asid_bits |
                                 {{(VALUE_W - PAGE_W){1'b0}}, mem_rdata_ff};
               end
               q_valid_in = 1'b0;
            end
            // prefetch the next entry when the read register frees up
            rd_en = (rd_idx_ff < count_ff) && (!q_valid_ff || out_load);
            if (rd_en) begin
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
               q_valid_in = 1'b1;
            end
            if ((rd_idx_ff == count_ff) && !q_valid_ff) begin
               state_in = ST_BARRIER;
            end
         end

         ST_WHOLE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ASID;
               rsp_value_in = asid_bits;
               rsp_last_in  = 1'b0;
               state_in     = ST_BARRIER;
            end
         end

         ST_BARRIER: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_BARRIER;
               rsp_value_in = '0;
               rsp_last_in  = 1'b1;
               count_in     = '0;
               if (store_after_ff) begin
                  mem_we         = 1'b1;
                  mem_waddr      = '0;
                  mem_wdata      = held_page_ff;
                  count_in       = CNT_W'(1);
                  store_after_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         rd_idx_ff      <= '0;
         q_valid_ff     <= 1'b0;
         store_after_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         rd_idx_ff      <= rd_idx_in;
         q_valid_ff     <= q_valid_in;
         store_after_ff <= store_after_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      held_page_ff <= held_page_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // page RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         mem_rdata_ff <= page_mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

endmodule
